### rtl/wfpd_pkg.sv
// Shared types, register indexes and reset values for the wall-following PD speed block.
package wfpd_pkg;

    // Field widths
    localparam int DIST_W  = 12;
    localparam int GAIN_W  = 12;
    localparam int SPEED_W = 8;
    localparam int ERR_W   = 13;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int PKP_W   = GAIN_W + ERR_W;
    localparam int PKD_W   = GAIN_W + DIFF_W;
    localparam int ACC_W   = PKD_W + 1;
    localparam int FRAC_W  = 8;
    localparam int SPD_W   = ACC_W - FRAC_W;
    localparam int IDX_W   = 4;
    localparam int CFG_W   = 12;

    // Register reset values
    localparam logic [DIST_W-1:0]  RST_WALL_TARGET = 12'd50;
    localparam logic [DIST_W-1:0]  RST_NEAR_LIMIT  = 12'd120;
    localparam logic [GAIN_W-1:0]  RST_KP_GAIN     = 12'd410;
    localparam logic [GAIN_W-1:0]  RST_KD_PER_STEP = 12'd1536;
    localparam logic [SPEED_W-1:0] RST_BASE_RIGHT  = 8'd175;
    localparam logic [SPEED_W-1:0] RST_LEFT_SPEED  = 8'd120;
    localparam logic [SPEED_W-1:0] RST_SPEED_MAX   = 8'd220;
    localparam logic [SPEED_W-1:0] RST_SPEED_MIN   = 8'd130;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_WALL_TARGET = 4'd0,
        REG_NEAR_LIMIT  = 4'd1,
        REG_KP_GAIN     = 4'd2,
        REG_KD_PER_STEP = 4'd3,
        REG_BASE_RIGHT  = 4'd4,
        REG_LEFT_SPEED  = 4'd5,
        REG_SPEED_MAX   = 4'd6,
        REG_SPEED_MIN   = 4'd7
    } t_reg_idx;

endpackage

### rtl/wall_follow_pd_speed.sv
// Top level of the wall-following PD speed controller.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one right and one left
//   wall distance per transaction. Output channel (o_out_valid / i_out_stall)
//   carries the right PWM, the left PWM and the signed steering error.
//   The configuration channel (i_cfg_valid / o_cfg_ready) writes one register
//   per transaction by index; it is always ready. Write it only while idle.
//   Each taken item moves from the input register to the result register.
//   Throughput: one transaction per cycle while the receiver does not stall;
//   the input register and the result register each hold one item, with the whole
//   computation between them. The previous-error register updates when an item moves to the result.
//   Reset (synchronous, active low) clears both valid bits and the previous
//   error and loads the register defaults.
//   When the receiver stalls, the result holds and an empty input register
//   still takes one more item; o_in_stall rises only when both are full.
module wall_follow_pd_speed
    import wfpd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [DIST_W-1:0]   i_right_dist_mm,
    input  logic [DIST_W-1:0]   i_left_dist_mm,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [SPEED_W-1:0]  o_right_pwm,
    output logic [SPEED_W-1:0]  o_left_pwm,
    output logic signed [ERR_W-1:0] o_wall_error,
    // configuration channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    // Configuration registers
    logic [DIST_W-1:0]  r_wall_target;
    logic [DIST_W-1:0]  r_near_limit;
    logic [GAIN_W-1:0]  r_kp_gain;
    logic [GAIN_W-1:0]  r_kd_per_step;
    logic [SPEED_W-1:0] r_base_right;
    logic [SPEED_W-1:0] r_left_speed;
    logic [SPEED_W-1:0] r_speed_max;
    logic [SPEED_W-1:0] r_speed_min;

    // Valid bits and stage handshake
    logic r_v1, r_vo;
    logic w_rdy1, w_rdyo;

    // Stage payloads
    logic [DIST_W-1:0]        r_right, r_left;
    logic signed [ERR_W-1:0]  r_last_err;
    logic [SPEED_W-1:0]       r_out_pwm;
    logic signed [ERR_W-1:0]  r_out_err;

    logic signed [ERR_W-1:0]  n_err;
    logic signed [DIFF_W-1:0] n_diff;
    logic signed [PKP_W-1:0]  n_pkp;
    logic signed [PKD_W-1:0]  n_pkd;
    logic signed [ACC_W-1:0]  n_acc, n_adj;
    logic signed [SPD_W-1:0]  n_spd;
    logic [SPEED_W-1:0]       n_pwm;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_target <= RST_WALL_TARGET;
            r_near_limit  <= RST_NEAR_LIMIT;
            r_kp_gain     <= RST_KP_GAIN;
            r_kd_per_step <= RST_KD_PER_STEP;
            r_base_right  <= RST_BASE_RIGHT;
            r_left_speed  <= RST_LEFT_SPEED;
            r_speed_max   <= RST_SPEED_MAX;
            r_speed_min   <= RST_SPEED_MIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_WALL_TARGET: r_wall_target <= i_cfg_data;
                REG_NEAR_LIMIT:  r_near_limit  <= i_cfg_data;
                REG_KP_GAIN:     r_kp_gain     <= i_cfg_data;
                REG_KD_PER_STEP: r_kd_per_step <= i_cfg_data;
                REG_BASE_RIGHT:  r_base_right  <= i_cfg_data[SPEED_W-1:0];
                REG_LEFT_SPEED:  r_left_speed  <= i_cfg_data[SPEED_W-1:0];
                REG_SPEED_MAX:   r_speed_max   <= i_cfg_data[SPEED_W-1:0];
                REG_SPEED_MIN:   r_speed_min   <= i_cfg_data[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance a stage when it is empty or its successor takes its item
    assign w_rdyo     = !r_vo || !i_out_stall;
    assign w_rdy1     = !r_v1 || w_rdyo;
    assign o_in_stall = !w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdyo) r_vo <= r_v1;
        end
    end

    // Input register: capture the distances
    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_in_valid) begin
            r_right <= i_right_dist_mm;
            r_left  <= i_left_dist_mm;
        end
    end

    // Pick the followed wall and form the error and its step difference
    always_comb begin
        if (r_right < r_near_limit) begin
            n_err = $signed({1'b0, r_wall_target}) - $signed({1'b0, r_right});
        end else if (r_left < r_near_limit) begin
            n_err = $signed({1'b0, r_left}) - $signed({1'b0, r_wall_target});
        end else begin
            n_err = '0;
        end
        n_diff = $signed({n_err[ERR_W-1], n_err})
               - $signed({r_last_err[ERR_W-1], r_last_err});
    end

    // Update the previous error when the item moves to the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_err <= '0;
        end else if (r_v1 && w_rdyo) begin
            r_last_err <= n_err;
        end
    end

    // Form the proportional and derivative products
    assign n_pkp = $signed({{ERR_W{1'b0}}, r_kp_gain})
                 * $signed({{GAIN_W{n_err[ERR_W-1]}}, n_err});
    assign n_pkd = $signed({{DIFF_W{1'b0}}, r_kd_per_step})
                 * $signed({{GAIN_W{n_diff[DIFF_W-1]}}, n_diff});

    // Sum in Q.8, truncate toward zero, then clamp high first and low second
    always_comb begin
        n_acc = $signed({{(ACC_W-SPEED_W-FRAC_W){1'b0}}, r_base_right, {FRAC_W{1'b0}}})
              + $signed({{(ACC_W-PKP_W){n_pkp[PKP_W-1]}}, n_pkp})
              + $signed({n_pkd[PKD_W-1], n_pkd});
        n_adj = n_acc[ACC_W-1]
              ? n_acc + $signed({{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}})
              : n_acc;
        n_spd = n_adj[ACC_W-1:FRAC_W];
        if (n_spd > $signed({{(SPD_W-SPEED_W){1'b0}}, r_speed_max})) begin
            n_pwm = r_speed_max;
        end else if (n_spd < $signed({{(SPD_W-SPEED_W){1'b0}}, r_speed_min})) begin
            n_pwm = r_speed_min;
        end else begin
            n_pwm = n_spd[SPEED_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_v1 && w_rdyo) begin
            r_out_pwm <= n_pwm;
            r_out_err <= n_err;
        end
    end

    assign o_out_valid  = r_vo;
    assign o_right_pwm  = r_out_pwm;
    assign o_left_pwm   = r_left_speed;
    assign o_wall_error = r_out_err;

endmodule

### rtl/wfpd_checker.sv
// Port-level checker for the wall-following PD speed block and its bind.
module wfpd_checker
    import wfpd_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [SPEED_W-1:0]       o_right_pwm,
    input logic signed [ERR_W-1:0]  o_wall_error
);

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Input back-pressure only when a full result is held by the receiver
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output back-pressure");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_right_pwm) && $stable(o_wall_error)))
        else $error("stalled result changed");

    // Error never reaches the most negative code
    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_wall_error != $signed({1'b1, {(ERR_W-1){1'b0}}})))
        else $error("wall error out of range");

endmodule

bind wall_follow_pd_speed wfpd_checker u_wfpd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_right_pwm  (o_right_pwm),
    .o_wall_error (o_wall_error)
);

### tb/wfpd_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard that predicts and checks the wall-following PD speed results.
package wfpd_tb_pkg;
    import wfpd_pkg::*;

    typedef struct packed {
        logic [SPEED_W-1:0]      right_pwm;
        logic [SPEED_W-1:0]      left_pwm;
        logic signed [ERR_W-1:0] wall_error;
    } t_pwm_result;

    class wall_pd_scoreboard;
        // register copies, updated on every write transaction to a known index
        logic [DIST_W-1:0]  target_mm;
        logic [DIST_W-1:0]  near_mm;
        logic [GAIN_W-1:0]  kp;
        logic [GAIN_W-1:0]  kd;
        logic [SPEED_W-1:0] base_spd;
        logic [SPEED_W-1:0] left_spd;
        logic [SPEED_W-1:0] spd_max;
        logic [SPEED_W-1:0] spd_min;
        int                 prev_err;
        t_pwm_result        pwm_expected[$];
        int                 n_fail;
        int                 n_checked;

        function new();
            target_mm = RST_WALL_TARGET;
            near_mm   = RST_NEAR_LIMIT;
            kp        = RST_KP_GAIN;
            kd        = RST_KD_PER_STEP;
            base_spd  = RST_BASE_RIGHT;
            left_spd  = RST_LEFT_SPEED;
            spd_max   = RST_SPEED_MAX;
            spd_min   = RST_SPEED_MIN;
            prev_err  = 0;
            n_fail    = 0;
            n_checked = 0;
        endfunction

        // Mirror one register write; unknown indexes leave everything alone
        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_WALL_TARGET: target_mm = data[DIST_W-1:0];
                REG_NEAR_LIMIT:  near_mm   = data[DIST_W-1:0];
                REG_KP_GAIN:     kp        = data[GAIN_W-1:0];
                REG_KD_PER_STEP: kd        = data[GAIN_W-1:0];
                REG_BASE_RIGHT:  base_spd  = data[SPEED_W-1:0];
                REG_LEFT_SPEED:  left_spd  = data[SPEED_W-1:0];
                REG_SPEED_MAX:   spd_max   = data[SPEED_W-1:0];
                REG_SPEED_MIN:   spd_min   = data[SPEED_W-1:0];
                default: ;
            endcase
        endfunction

        // Work out the PWM pair and steering error for one accepted distance pair
        function void take_distances(logic [DIST_W-1:0] right_mm, logic [DIST_W-1:0] left_mm);
            int          err;
            longint      acc;
            longint      spd;
            t_pwm_result res;
            if (right_mm < near_mm)
                err = int'(target_mm) - int'(right_mm);
            else if (left_mm < near_mm)
                err = int'(left_mm) - int'(target_mm);
            else
                err = 0;
            acc = longint'(base_spd) * 256 + longint'(kp) * err
                + longint'(kd) * (err - prev_err);
            // signed division truncates toward zero
            spd = acc / 256;
            // upper limit wins over lower limit
            if (spd > longint'(spd_max))
                spd = spd_max;
            else if (spd < longint'(spd_min))
                spd = spd_min;
            prev_err       = err;
            res.right_pwm  = SPEED_W'(spd);
            res.left_pwm   = left_spd;
            res.wall_error = ERR_W'(err);
            pwm_expected.push_back(res);
        endfunction

        // Compare one output transaction against the oldest prediction
        function void match_result(logic [SPEED_W-1:0] right_pwm, logic [SPEED_W-1:0] left_pwm,
                                   logic signed [ERR_W-1:0] wall_error);
            t_pwm_result want;
            if (pwm_expected.size() == 0) begin
                $error("unexpected result: right_pwm %0d left_pwm %0d wall_error %0d",
                       right_pwm, left_pwm, $signed(wall_error));
                n_fail++;
                return;
            end
            want = pwm_expected.pop_front();
            n_checked++;
            if (want.right_pwm !== right_pwm) begin
                $error("right_pwm mismatch: expected %0d, actual %0d", want.right_pwm, right_pwm);
                n_fail++;
            end
            if (want.left_pwm !== left_pwm) begin
                $error("left_pwm mismatch: expected %0d, actual %0d", want.left_pwm, left_pwm);
                n_fail++;
            end
            if (want.wall_error !== wall_error) begin
                $error("wall_error mismatch: expected %0d, actual %0d",
                       $signed(want.wall_error), $signed(wall_error));
                n_fail++;
            end
        endfunction
    endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the wall-following PD speed controller.
module tb_top;
    import wfpd_pkg::*;
    import wfpd_tb_pkg::*;

    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 104;
    localparam int SETTLE_CYCLES   = 6;
    localparam int LONG_HOLD       = 150;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [DIST_W-1:0]       i_right_dist_mm = '0;
    logic [DIST_W-1:0]       i_left_dist_mm = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [SPEED_W-1:0]      o_right_pwm;
    logic [SPEED_W-1:0]      o_left_pwm;
    logic signed [ERR_W-1:0] o_wall_error;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;

    wall_pd_scoreboard board = new();

    // stimulus shaping, shared with the receiver process
    logic [DIST_W-1:0] cur_limit = RST_NEAR_LIMIT;
    logic [DIST_W-1:0] cur_target = RST_WALL_TARGET;
    bit                gap_mode = 1'b0;
    int                stall_pct = 0;
    int                hold_req = 0;
    int                n_holds = 0;
    int                n_sent = 0;
    int                n_settings = 0;

    wall_follow_pd_speed uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_right_dist_mm (i_right_dist_mm),
        .i_left_dist_mm  (i_left_dist_mm),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_right_pwm     (o_right_pwm),
        .o_left_pwm      (o_left_pwm),
        .o_wall_error    (o_wall_error),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Check output transactions and drive the receiver stall
    initial begin : receiver
        int run_left;
        run_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                board.match_result(o_right_pwm, o_left_pwm, o_wall_error);
            end
            if (hold_req > 0) begin
                run_left = hold_req;
                hold_req = 0;
                n_holds++;
            end else if (run_left == 0 && stall_pct > 0 && $urandom_range(99) < stall_pct) begin
                run_left = ($urandom_range(9) == 0) ? $urandom_range(60, 15) : $urandom_range(3, 1);
            end
            if (run_left > 0) begin
                i_out_stall <= 1'b1;
                run_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offer one distance pair, optionally after a gap, and hold it until taken
    task automatic send_dist(input logic [DIST_W-1:0] right_mm, input logic [DIST_W-1:0] left_mm);
        int roll;
        int gap;
        roll = $urandom_range(99);
        gap = 0;
        if (gap_mode && roll >= 60)
            gap = (roll < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_right_dist_mm <= right_mm;
        i_left_dist_mm  <= left_mm;
        do @(posedge i_clk); while (o_in_stall);
        board.take_distances(right_mm, left_mm);
        n_sent++;
    endtask

    // Stop offering and wait until every predicted result has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pwm_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
    endtask

    // Write all eight registers, then one random unused index above them that must be ignored
    task automatic apply_settings(input logic [CFG_W-1:0] tgt, input logic [CFG_W-1:0] lim,
                                  input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] kd,
                                  input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] lft,
                                  input logic [CFG_W-1:0] smax, input logic [CFG_W-1:0] smin);
        write_reg(REG_WALL_TARGET, tgt);
        write_reg(REG_NEAR_LIMIT, lim);
        write_reg(REG_KP_GAIN, kp);
        write_reg(REG_KD_PER_STEP, kd);
        write_reg(REG_BASE_RIGHT, base);
        write_reg(REG_LEFT_SPEED, lft);
        write_reg(REG_SPEED_MAX, smax);
        write_reg(REG_SPEED_MIN, smin);
        write_reg(IDX_W'($urandom_range(2 ** IDX_W - 1, int'(REG_SPEED_MIN) + 1)),
                  CFG_W'($urandom));
        i_cfg_valid <= 1'b0;
        cur_target = tgt[DIST_W-1:0];
        cur_limit  = lim[DIST_W-1:0];
        n_settings++;
    endtask

    // Register value: extremes, near the usual value, or anywhere; junk above 8-bit fields
    function automatic logic [CFG_W-1:0] pick_setting(input int width,
                                                      input logic [CFG_W-1:0] usual);
        int               roll;
        logic [CFG_W-1:0] top;
        logic [CFG_W-1:0] val;
        roll = $urandom_range(9);
        top = CFG_W'((1 << width) - 1);
        if (roll == 0)
            val = '0;
        else if (roll == 1)
            val = top;
        else if (roll < 6)
            val = CFG_W'($urandom_range(int'(usual) + int'(usual) / 2, int'(usual) / 2)) & top;
        else
            val = CFG_W'($urandom_range(int'(top)));
        return val | (CFG_W'($urandom) & ~top);
    endfunction

    // Distance: extremes, around the near limit, below it, at the target, or anywhere
    function automatic logic [DIST_W-1:0] pick_dist();
        int roll;
        int v;
        roll = $urandom_range(9);
        case (roll)
            0: v = 0;
            1: v = 2 ** DIST_W - 1;
            2, 3: v = int'(cur_limit) + int'($urandom_range(2)) - 1;
            4, 5, 6: v = (cur_limit == 0) ? 0 : int'($urandom_range(int'(cur_limit) - 1));
            7: v = int'(cur_target);
            default: v = int'($urandom_range(2 ** DIST_W - 1));
        endcase
        if (v < 0) v = 0;
        if (v > 2 ** DIST_W - 1) v = 2 ** DIST_W - 1;
        return DIST_W'(v);
    endfunction

    initial begin : stimulus
        int ph;
        int k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: both walls, right wall only, left wall only, none, limit edges
        send_dist(12'd0, 12'd0);
        send_dist(12'd4095, 12'd0);
        send_dist(12'd4095, 12'd4095);
        send_dist(12'd119, 12'd4095);
        send_dist(12'd120, 12'd119);
        send_dist(12'd120, 12'd120);
        send_dist(12'd50, 12'd4095);
        send_dist(12'd4095, 12'd50);
        send_dist(12'd0, 12'd4095);
        send_dist(12'd4095, 12'd4095);

        // Largest gains and errors: full error swing drives the derivative term hardest
        drain_results();
        apply_settings(12'd4095, 12'd4095, 12'd4095, 12'd4095,
                       12'hFFF, 12'hFFF, 12'hFFF, 12'h000);
        send_dist(12'd0, 12'd0);
        send_dist(12'd4095, 12'd0);
        send_dist(12'd4095, 12'd4095);
        send_dist(12'd0, 12'd4095);
        send_dist(12'd4095, 12'd4094);

        // All zero: no wall ever counts as near
        drain_results();
        apply_settings('0, '0, '0, '0, '0, '0, '0, '0);
        send_dist(12'd0, 12'd0);
        send_dist(12'd4095, 12'd4095);

        // Lower limit above upper limit: high values take the max, low ones the min
        drain_results();
        apply_settings(12'd100, 12'd300, 12'd256, 12'd0,
                       12'd128, 12'd7, 12'd50, 12'd200);
        send_dist(12'd0, 12'd4095);
        send_dist(12'd4095, 12'd0);
        send_dist(12'd4095, 12'd75);

        // Random phases, each with its own register settings and idling pattern
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            apply_settings(pick_setting(DIST_W, RST_WALL_TARGET),
                           pick_setting(DIST_W, RST_NEAR_LIMIT),
                           pick_setting(GAIN_W, RST_KP_GAIN),
                           pick_setting(GAIN_W, RST_KD_PER_STEP),
                           pick_setting(SPEED_W, RST_BASE_RIGHT),
                           pick_setting(SPEED_W, RST_LEFT_SPEED),
                           pick_setting(SPEED_W, RST_SPEED_MAX),
                           pick_setting(SPEED_W, RST_SPEED_MIN));
            gap_mode  = (ph % 3 != 0);
            stall_pct = (ph % 4 == 1) ? 0 : ((ph % 4 == 2) ? 40 : 10);
            // back-to-back offers against a long receiver hold fill the pipeline
            if (ph == 3 || ph == 8) begin
                gap_mode = 1'b0;
                hold_req = LONG_HOLD;
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph % 5 == 4 && k == ITEMS_PER_PHASE / 2)
                    drain_results();
                send_dist(pick_dist(), pick_dist());
            end
        end

        drain_results();
        $display("Covered %0d distance pairs and %0d checked results under %0d register settings,",
                 n_sent, board.n_checked, n_settings);
        $display("with random gaps and stalls and %0d long receiver holds.", n_holds);
        if (board.n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin : watchdog
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### wall_follow_pd_speed.f
rtl/wfpd_pkg.sv
rtl/wall_follow_pd_speed.sv
rtl/wfpd_checker.sv
tb/wfpd_tb_pkg.sv
tb/tb_top.sv
